/* hw/rtl/ggdc_pkg.sv */
package ggdc_pkg;

    localparam int XY_W   = 24;
    localparam int Z_W    = 20;
    localparam int HD_W   = 15;
    localparam int DIST_W = 19;
    localparam int NUM_W  = 28;
    localparam int TT_W   = 16;
    localparam int Q_W    = 15;
    localparam int RATE_W = 18;

    localparam logic [1:0] CFG_GOAL_X   = 2'd0;
    localparam logic [1:0] CFG_GOAL_Y   = 2'd1;
    localparam logic [1:0] CFG_TOL      = 2'd2;
    localparam logic [1:0] CFG_TRAVEL_T = 2'd3;

    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [15:0] GAIN_INV_Q16 = 16'd39797;
    localparam logic [Q_W-1:0] SPEED_MAX = 15'h7fff;

    // payload carried alongside the divider
    typedef struct packed {
        logic                     arrived;
        logic                     sat;
        logic signed [RATE_W-1:0] rate;
    } t_side;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = 20'sd51472;
            5'd1:  v = 20'sd30386;
            5'd2:  v = 20'sd16055;
            5'd3:  v = 20'sd8150;
            5'd4:  v = 20'sd4091;
            5'd5:  v = 20'sd2047;
            5'd6:  v = 20'sd1024;
            5'd7:  v = 20'sd512;
            5'd8:  v = 20'sd256;
            5'd9:  v = 20'sd128;
            5'd10: v = 20'sd64;
            5'd11: v = 20'sd32;
            5'd12: v = 20'sd16;
            5'd13: v = 20'sd8;
            5'd14: v = 20'sd4;
            5'd15: v = 20'sd2;
            5'd16: v = 20'sd1;
            5'd17: v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/ggdc_cordic_cell.sv */
module ggdc_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_v,
    input  logic signed [ggdc_pkg::XY_W-1:0]   i_x,
    input  logic signed [ggdc_pkg::XY_W-1:0]   i_y,
    input  logic signed [ggdc_pkg::Z_W-1:0]    i_z,
    input  logic signed [ggdc_pkg::HD_W-1:0]   i_hd,
    output logic                               o_v,
    output logic signed [ggdc_pkg::XY_W-1:0]   o_x,
    output logic signed [ggdc_pkg::XY_W-1:0]   o_y,
    output logic signed [ggdc_pkg::Z_W-1:0]    o_z,
    output logic signed [ggdc_pkg::HD_W-1:0]   o_hd
);
    logic                             r_v;
    logic signed [ggdc_pkg::XY_W-1:0] r_x, r_y, n_x, n_y, xs, ys;
    logic signed [ggdc_pkg::Z_W-1:0]  r_z, n_z, at;
    logic signed [ggdc_pkg::HD_W-1:0] r_hd;

    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        at = ggdc_pkg::atan_q16(5'(STAGE));
        if (i_y >= 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + at;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_z  <= n_z;
            r_hd <= i_hd;
        end
    end

    assign o_v  = r_v;
    assign o_x  = r_x;
    assign o_y  = r_y;
    assign o_z  = r_z;
    assign o_hd = r_hd;
endmodule

/* hw/rtl/ggdc_div_cell.sv */
module ggdc_div_cell #(
    parameter int BIT = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [ggdc_pkg::TT_W-1:0]     i_tt,
    input  logic                          i_v,
    input  logic [ggdc_pkg::TT_W-1:0]     i_rem,
    input  logic [ggdc_pkg::Q_W-1:0]      i_num,
    input  logic [ggdc_pkg::Q_W-1:0]      i_q,
    input  ggdc_pkg::t_side               i_side,
    output logic                          o_v,
    output logic [ggdc_pkg::TT_W-1:0]     o_rem,
    output logic [ggdc_pkg::Q_W-1:0]      o_num,
    output logic [ggdc_pkg::Q_W-1:0]      o_q,
    output ggdc_pkg::t_side               o_side
);
    logic                          r_v;
    logic [ggdc_pkg::TT_W-1:0]     r_rem, n_rem;
    logic [ggdc_pkg::Q_W-1:0]      r_num, r_q, n_q;
    ggdc_pkg::t_side               r_side;
    logic [ggdc_pkg::TT_W:0]       trial, diff;

    always_comb begin
        trial = {i_rem, i_num[BIT]};
        diff  = trial - {1'b0, i_tt};
        n_q   = i_q;
        if (trial >= {1'b0, i_tt}) begin
            n_rem  = diff[ggdc_pkg::TT_W-1:0];
            n_q[BIT] = 1'b1;
        end else begin
            n_rem  = trial[ggdc_pkg::TT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_num  <= i_num;
            r_q    <= n_q;
            r_side <= i_side;
        end
    end

    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_num  = r_num;
    assign o_q    = r_q;
    assign o_side = r_side;
endmodule

/* hw/rtl/go_to_goal_drive_command_top.sv */
// Go-to-goal drive command. Each pose transaction (x, y, heading) yields one
// command transaction: forward speed 1.75 * distance / travel_time and turn rate
// 4 * (bearing - heading), both saturated and both zero with arrived set once
// the distance is within the tolerance. The core is a row of CORDIC cells, one
// per rotation, then a row of fifteen restoring divider cells. A pose is taken
// every cycle unless the output stalls, and it passes both rows on its way to
// the output register. Back-pressure on the output stalls the whole row.
// Write the goal and limit registers only while no transaction is in flight.
module go_to_goal_drive_command_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // pos_x, pos_y, heading, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // linear_speed, angular_rate, arrived, zero pad
);
    localparam int N  = CORDIC_STAGES;
    localparam int XW = ggdc_pkg::XY_W;
    localparam int ZW = ggdc_pkg::Z_W;
    localparam int HW = ggdc_pkg::HD_W;
    localparam int QW = ggdc_pkg::Q_W;
    localparam int TW = ggdc_pkg::TT_W;

    logic signed [15:0] r_goal_x, r_goal_y;
    logic [14:0]        r_tol;
    logic [TW-1:0]      r_tt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_tol    <= 15'd256;
            r_tt     <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ggdc_pkg::CFG_GOAL_X:   r_goal_x <= i_cfg_wdata;
                ggdc_pkg::CFG_GOAL_Y:   r_goal_y <= i_cfg_wdata;
                ggdc_pkg::CFG_TOL:      r_tol    <= i_cfg_wdata[14:0];
                ggdc_pkg::CFG_TRAVEL_T: r_tt     <= i_cfg_wdata;
            endcase
        end
    end

    logic en;
    logic r_ov;
    assign en = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    // offset and quadrant pre-rotation
    logic signed [16:0] dx, dy;
    logic signed [XW-1:0] sx, sy, n0_x, n0_y;
    logic signed [ZW-1:0] n0_z;
    always_comb begin
        dx = 17'(r_goal_x) - 17'(signed'(s_axis_tdata[15:0]));
        dy = 17'(r_goal_y) - 17'(signed'(s_axis_tdata[31:16]));
        sx = XW'(dx) <<< 4;
        sy = XW'(dy) <<< 4;
        n0_x = sx;
        n0_y = sy;
        n0_z = '0;
        if (sx < 0) begin
            if (sy >= 0) begin
                n0_x = sy;
                n0_y = -sx;
                n0_z = ggdc_pkg::HALF_PI_Q16;
            end else begin
                n0_x = -sy;
                n0_y = sx;
                n0_z = -ggdc_pkg::HALF_PI_Q16;
            end
        end
    end

    logic                 cv [N+1];
    logic signed [XW-1:0] cx [N+1];
    logic signed [XW-1:0] cy [N+1];
    logic signed [ZW-1:0] cz [N+1];
    logic signed [HW-1:0] ch [N+1];
    logic                 r0_v;
    logic signed [XW-1:0] r0_x, r0_y;
    logic signed [ZW-1:0] r0_z;
    logic signed [HW-1:0] r0_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_x  <= n0_x;
            r0_y  <= n0_y;
            r0_z  <= n0_z;
            r0_hd <= s_axis_tdata[46:32];
        end
    end

    assign cv[0] = r0_v;
    assign cx[0] = r0_x;
    assign cy[0] = r0_y;
    assign cz[0] = r0_z;
    assign ch[0] = r0_hd;

    for (genvar g = 0; g < N; g++) begin : g_cordic
        ggdc_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_v(cv[g]), .i_x(cx[g]), .i_y(cy[g]), .i_z(cz[g]), .i_hd(ch[g]),
            .o_v(cv[g+1]), .o_x(cx[g+1]), .o_y(cy[g+1]), .o_z(cz[g+1]),
            .o_hd(ch[g+1])
        );
    end

    // gain correction and bearing
    logic [XW-2:0] xc;
    logic [XW+15:0] prod;
    logic signed [ZW-1:0] zr;
    logic                 r1_v;
    logic [ggdc_pkg::DIST_W-1:0] r1_dist;
    logic signed [15:0]   r1_bear;
    logic signed [HW-1:0] r1_hd;

    always_comb begin
        xc   = (cx[N] < 0) ? '0 : cx[N][XW-2:0];
        prod = (XW+16)'(xc) * (XW+16)'(ggdc_pkg::GAIN_INV_Q16) + (XW+16)'(1 << 19);
        zr   = (cz[N] + ZW'(8)) >>> 4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= cv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dist <= prod[20 +: ggdc_pkg::DIST_W];
            r1_bear <= zr[15:0];
            r1_hd   <= ch[N];
        end
    end

    // arrival, turn rate and divider setup
    logic signed [16:0] diff;
    logic signed [18:0] rate4;
    logic [ggdc_pkg::NUM_W-1:0] num;
    ggdc_pkg::t_side n2_side;
    always_comb begin
        diff  = 17'(r1_bear) - 17'(r1_hd);
        rate4 = 19'(diff) <<< 2;
        n2_side.arrived = (r1_dist <= ggdc_pkg::DIST_W'(r_tol));
        if (rate4 > 19'sd131071) begin
            n2_side.rate = 18'sd131071;
        end else if (rate4 < -19'sd131072) begin
            n2_side.rate = -18'sd131072;
        end else begin
            n2_side.rate = rate4[17:0];
        end
        num = ggdc_pkg::NUM_W'(r1_dist) * ggdc_pkg::NUM_W'(448);
        // quotient would reach 2^15: saturate, also covers zero travel time
        n2_side.sat = (TW'(num[ggdc_pkg::NUM_W-1:QW]) >= r_tt);
    end

    logic            dv [QW+1];
    logic [TW-1:0]   dr [QW+1];
    logic [QW-1:0]   dn [QW+1];
    logic [QW-1:0]   dq [QW+1];
    ggdc_pkg::t_side ds [QW+1];
    logic            r2_v;
    logic [TW-1:0]   r2_rem;
    logic [QW-1:0]   r2_num;
    ggdc_pkg::t_side r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_rem  <= TW'(num[ggdc_pkg::NUM_W-1:QW]);
            r2_num  <= num[QW-1:0];
            r2_side <= n2_side;
        end
    end

    assign dv[0] = r2_v;
    assign dr[0] = r2_rem;
    assign dn[0] = r2_num;
    assign dq[0] = '0;
    assign ds[0] = r2_side;

    for (genvar k = 0; k < QW; k++) begin : g_div
        ggdc_div_cell #(.BIT(QW-1-k)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_tt(r_tt),
            .i_v(dv[k]), .i_rem(dr[k]), .i_num(dn[k]), .i_q(dq[k]), .i_side(ds[k]),
            .o_v(dv[k+1]), .o_rem(dr[k+1]), .o_num(dn[k+1]), .o_q(dq[k+1]),
            .o_side(ds[k+1])
        );
    end

    // output register
    logic [QW-1:0]            r_speed;
    logic signed [17:0]       r_rate;
    logic                     r_arr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_arr   <= ds[QW].arrived;
            r_rate  <= ds[QW].arrived ? '0 : ds[QW].rate;
            r_speed <= ds[QW].arrived ? '0 :
                       (ds[QW].sat ? ggdc_pkg::SPEED_MAX : dq[QW]);
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, r_arr, r_rate, r_speed};

`ifndef SYNTH
    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_arr) |-> (r_speed == '0 && r_rate == '0))
        else $error("arrived command not zero");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r0_v)
        else $error("accepted pose not in first stage");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r1_v) && $stable(r2_v) && $stable(cv[N])))
        else $error("pipeline moved during stall");
`endif
endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int  STAGES     = 16;
    localparam int  LATENCY    = STAGES + 19;
    localparam int  SETTLE     = LATENCY + 8;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam longint HALF_PI = 102944;
    localparam longint GAIN_INV = 39797;
    localparam longint ATAN_TBL [0:23] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1, 1, 0, 0, 0, 0, 0, 0};

    typedef struct packed {
        logic [14:0]        speed;
        logic signed [17:0] rate;
        logic               arrived;
    } t_drive_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // pos_x, pos_y, heading, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // linear_speed, angular_rate, arrived, zero pad

    // shadow copy of the goal and limit registers
    logic signed [15:0] goal_x_q;
    logic signed [15:0] goal_y_q;
    logic [14:0]        tol_q;
    logic [15:0]        travel_q;

    t_drive_cmd cmd_q[$];
    int         pose_idle_pct;
    int         cmd_stall_pct;
    logic       hold_cmd;
    int         err_cnt;
    longint     cyc_cnt;

    go_to_goal_drive_command_top #(.CORDIC_STAGES(STAGES)) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_drive_cmd predict_cmd(logic signed [15:0] px, logic signed [15:0] py,
                                               logic signed [14:0] hd);
        longint x, y, z, t, xs, ys, distance, spd, rate, brg;
        t_drive_cmd c;
        x = (longint'(goal_x_q) - longint'(px)) * 16;
        y = (longint'(goal_y_q) - longint'(py)) * 16;
        z = 0;
        // pre-rotate into the right half plane
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI;
            end
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
            end
        end
        if (x < 0) x = 0;
        distance = (x * GAIN_INV + (64'sd1 <<< 19)) >>> 20;
        c = '0;
        if (distance <= longint'(tol_q)) begin
            c.arrived = 1'b1;
        end else begin
            brg = (z + 8) >>> 4;
            if (travel_q == 0) spd = 32767;
            else spd = distance * 448 / longint'(travel_q);
            if (spd > 32767) spd = 32767;
            rate = (brg - longint'(hd)) * 4;
            if (rate > 131071) rate = 131071;
            if (rate < -131072) rate = -131072;
            c.speed = spd[14:0];
            c.rate  = rate[17:0];
        end
        return c;
    endfunction

    task automatic wait_idle();
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [15:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (addr)
            ggdc_pkg::CFG_GOAL_X:   goal_x_q = val;
            ggdc_pkg::CFG_GOAL_Y:   goal_y_q = val;
            ggdc_pkg::CFG_TOL:      tol_q    = val[14:0];
            ggdc_pkg::CFG_TRAVEL_T: travel_q = val;
        endcase
    endtask

    task automatic set_goal(logic [15:0] gx, logic [15:0] gy, logic [14:0] tol,
                            logic [15:0] tt);
        write_reg(ggdc_pkg::CFG_GOAL_X, gx);
        write_reg(ggdc_pkg::CFG_GOAL_Y, gy);
        write_reg(ggdc_pkg::CFG_TOL, {1'b0, tol});
        write_reg(ggdc_pkg::CFG_TRAVEL_T, tt);
    endtask

    // called at a rising edge; returns at the edge the transaction happens, or after a random idle gap that follows it
    task automatic send_pose(logic [15:0] px, logic [15:0] py, logic [14:0] hd);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, hd, py, px};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        cmd_q.push_back(predict_cmd(px, py, hd));
        if ($urandom_range(99) < pose_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_pose();
        logic [15:0] px, py, dx, dy;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 35) begin
            px = 16'($urandom); py = 16'($urandom);
        end else if (sel < 70) begin
            // near the goal, around the tolerance circle
            dx = 16'($urandom_range(2 * tol_q + 8) - tol_q - 4);
            dy = 16'($urandom_range(2 * tol_q + 8) - tol_q - 4);
            px = goal_x_q - dx; py = goal_y_q - dy;
        end else if (sel < 85) begin
            px = goal_x_q - (($urandom_range(1)) ? 16'($urandom) : 16'h0);
            py = goal_y_q - (($urandom_range(1)) ? 16'h0 : 16'($urandom));
        end else begin
            px = ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
            py = ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
        end
        send_pose(px, py, 15'($urandom));
    endtask

    task automatic test_directed();
        set_goal(16'h0000, 16'h0000, 15'd256, 16'd256);
        send_pose(16'h0000, 16'h0000, 15'h0000);       // zero offset
        send_pose(16'h0080, 16'hff80, 15'h3fff);       // within tolerance
        send_pose(16'h7fff, 16'h7fff, 15'h4000);
        send_pose(16'h8000, 16'h8000, 15'h3fff);
        send_pose(16'h8000, 16'h7fff, 15'h0000);
        send_pose(16'h7fff, 16'h8000, 15'h0000);
        send_pose(16'h8000, 16'h0000, 15'h4000);       // bearing on the axis
        send_pose(16'h0000, 16'h8000, 15'h3fff);
        send_pose(16'h0000, 16'h7fff, 15'h1234);
        send_pose(16'h0101, 16'h0000, 15'h0000);       // just past tolerance
        end_burst();
        set_goal(16'h7fff, 16'h8000, 15'd0, 16'd0);    // zero travel time
        send_pose(16'h7fff, 16'h8000, 15'h0000);
        send_pose(16'h8000, 16'h7fff, 15'h4000);
        send_pose(16'h7ffe, 16'h8000, 15'h3fff);
        end_burst();
        set_goal(16'h8000, 16'h7fff, 15'h7fff, 16'hffff);
        send_pose(16'h7fff, 16'h8000, 15'h0000);
        send_pose(16'h0000, 16'h0000, 15'h0000);
        end_burst();
        set_goal(16'h1234, 16'hedcb, 15'd16, 16'd1);
        send_pose(16'h8000, 16'h8000, 15'h4000);
        send_pose(16'h7fff, 16'h7fff, 15'h3fff);
        send_pose(16'h1240, 16'hedcb, 15'h0000);
        end_burst();
    endtask

    task automatic test_random();
        int stall_tbl [4] = '{0, 0, 65, 16};
        int idle_tbl  [4] = '{0, 65, 0, 16};
        for (int ph = 0; ph < 8; ph++) begin
            end_burst();
            if (ph == 3) set_goal(16'h8000, 16'h7fff, 15'd0, 16'd1);
            else set_goal(16'($urandom), 16'($urandom), 15'($urandom_range(2000)),
                          ($urandom_range(3) == 0) ? 16'($urandom) :
                                                     16'($urandom_range(800, 1)));
            pose_idle_pct = idle_tbl[ph % 4];
            cmd_stall_pct = stall_tbl[ph % 4];
            repeat (180) send_random_pose();
        end
        end_burst();
        pose_idle_pct = 0;
        cmd_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        set_goal(16'h0400, 16'hfc00, 15'd64, 16'd128);
        cmd_stall_pct = 10;
        fork
            begin
                hold_cmd <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_cmd <= 1'b0;
            end
            repeat (120) send_random_pose();
        join
        end_burst();
    endtask

    task automatic test_drain_pause();
        set_goal(16'($urandom), 16'($urandom), 15'd300, 16'd200);
        cmd_stall_pct = 30;
        repeat (40) send_random_pose();
        end_burst();
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (40) send_random_pose();
        end_burst();
        cmd_stall_pct = 0;
    endtask

    // receiver ready
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_cmd && ($urandom_range(99) >= cmd_stall_pct);
    end

    // inputs are stable at the falling edge, so a transaction seen here
    // completes on the next rising edge
    always @(negedge i_clk) begin
        t_drive_cmd got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.speed   = m_axis_tdata[14:0];
            got.rate    = m_axis_tdata[32:15];
            got.arrived = m_axis_tdata[33];
            if (cmd_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected command: speed=%0d rate=%0d arrived=%0b",
                             got.speed, got.rate, got.arrived);
            end else begin
                want = cmd_q.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"mismatch: exp speed=%0d rate=%0d arrived=%0b, ",
                                  "got speed=%0d rate=%0d arrived=%0b"},
                                 want.speed, want.rate, want.arrived,
                                 got.speed, got.rate, got.arrived);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        cyc_cnt       = 0;
        err_cnt       = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = ggdc_pkg::CFG_GOAL_X;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        hold_cmd      = 1'b0;
        pose_idle_pct = 0;
        cmd_stall_pct = 0;
        goal_x_q      = '0;
        goal_y_q      = '0;
        tol_q         = 15'd256;
        travel_q      = 16'd256;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random();
        test_backpressure();
        test_drain_pause();

        wait_idle();
        if (err_cnt == 0 && cmd_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ggdc_pkg.sv
hw/rtl/ggdc_cordic_cell.sv
hw/rtl/ggdc_div_cell.sv
hw/rtl/go_to_goal_drive_command_top.sv
tb/tb.sv
